[hw/rtl/scmt_pkg.sv]
// ----------------------------------------------------------------------------
// scmt_pkg
// Types and codes shared by the sorted CAN message table and its channels.
// ----------------------------------------------------------------------------
package scmt_pkg;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_FIND   = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [28:0] msg_id;
        logic [28:0] accept_mask;
        logic        is_remote;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic [15:0] handler_tag;
        logic [4:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [28:0] found_id;
        logic [28:0] found_mask;
        logic        found_remote;
        logic [3:0]  found_length;
        logic [63:0] found_payload;
        logic [15:0] found_handler;
        logic [5:0]  entry_total;
    } t_out_item;

    // One stored table entry, as held in the entry memory.
    typedef struct packed {
        logic [28:0] id;
        logic [28:0] mask;
        logic        remote;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [15:0] handler;
    } t_entry;

endpackage

[hw/rtl/scmt_ifs.sv]
// ----------------------------------------------------------------------------
// scmt channel interfaces
// Valid/ready channels carrying the action item and the result item.
// ----------------------------------------------------------------------------
interface scmt_in_if;
    logic               valid;
    logic               ready;
    scmt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scmt_out_if;
    logic                valid;
    logic                ready;
    scmt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/scmt_ram.sv]
// ----------------------------------------------------------------------------
// scmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sorted_can_message_table.sv]
// ----------------------------------------------------------------------------
// sorted_can_message_table
// CAN message entries kept sorted by identifier in one entry memory.
// ----------------------------------------------------------------------------
//  channel | direction | payload                        | accepted when
//  i_in    | in        | action, id, entry fields, pos. | valid && ready
//  o_out   | out       | status, entry found, count     | valid && ready
//
// One item at a time. A search reads the entries one by one from the start
// of the table, reading in S_SRD and comparing in S_SCMP; each entry moved
// by insert or remove is read in S_MRD, then written in S_MWR. The memory
// has a single write port and a single read port. Reset empties the table
// at once. While a result is stalled the next item is still taken and
// worked on, but its result waits in the output step until the held one
// leaves.
// ----------------------------------------------------------------------------
module sorted_can_message_table #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scmt_in_if.sink     i_in,
    scmt_out_if.source  o_out
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam int TW = (CW > 6) ? CW : 6;
    localparam int EW = $bits(scmt_pkg::t_entry);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SRD  = 9'b000000010,
        S_SCMP = 9'b000000100,
        S_MRD  = 9'b000001000,
        S_MWR  = 9'b000010000,
        S_PUT  = 9'b000100000,
        S_PRD  = 9'b001000000,
        S_PCAP = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    scmt_pkg::t_in_item   r_item, n_item;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_count, n_count;
    logic [1:0]           r_status, n_status;
    scmt_pkg::t_entry     r_entry, n_entry;
    logic                 r_ovalid, n_ovalid;
    scmt_pkg::t_out_item  r_odata, n_odata;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    scmt_pkg::t_entry     ram_wdata, rd_entry;
    logic [EW-1:0]        ram_rdata;
    scmt_pkg::t_entry     new_entry;
    logic [3:0]           new_len;
    logic [CW:0]          j_plus;
    logic [PW-1:0]        pos_ext, count_pos;
    logic [TW-1:0]        count_tot;

    scmt_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_entry = scmt_pkg::t_entry'(ram_rdata);

    // Entry as it will be stored: remote frames keep no data bytes.
    always_comb begin
        if (r_item.is_remote) begin
            new_len = 4'd0;
        end else if (r_item.byte_count > 4'd8) begin
            new_len = 4'd8;
        end else begin
            new_len = r_item.byte_count;
        end
        new_entry.id      = r_item.msg_id;
        new_entry.mask    = r_item.accept_mask;
        new_entry.remote  = r_item.is_remote;
        new_entry.length  = new_len;
        new_entry.handler = r_item.handler_tag;
        for (int b = 0; b < 8; b++) begin
            new_entry.payload[8*b +: 8] = (4'(b) < new_len) ? r_item.payload[8*b +: 8] : 8'd0;
        end
    end

    assign j_plus    = {1'b0, r_j} + {{CW{1'b0}}, 1'b1};
    assign pos_ext   = PW'(r_item.position);
    assign count_pos = PW'(r_count);
    assign count_tot = TW'(r_count);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_j       = r_j;
        n_count   = r_count;
        n_status  = r_status;
        n_entry   = r_entry;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = new_entry;
        ram_raddr = r_idx[IW-1:0];

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item   = i_in.data;
                    n_idx    = '0;
                    n_status = scmt_pkg::ST_MISS;
                    n_entry  = '0;
                    unique case (i_in.data.action) inside
                        scmt_pkg::ACT_INSERT, scmt_pkg::ACT_REMOVE,
                        scmt_pkg::ACT_FIND: n_state = S_SRD;
                        scmt_pkg::ACT_READ: n_state = S_PRD;
                        scmt_pkg::ACT_CLEAR: begin
                            n_count  = '0;
                            n_status = scmt_pkg::ST_OK;
                            n_state  = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SRD: begin
                if (r_idx >= r_count) begin
                    // Identifier absent; r_idx is where it would go.
                    if (r_item.action == scmt_pkg::ACT_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = scmt_pkg::ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_j     = r_count;
                            n_state = S_MRD;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (rd_entry.id < r_item.msg_id) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SRD;
                end else if (rd_entry.id == r_item.msg_id) begin
                    n_status = scmt_pkg::ST_OK;
                    if (r_item.action == scmt_pkg::ACT_INSERT) begin
                        ram_we  = 1'b1;
                        n_entry = new_entry;
                        n_state = S_OUT;
                    end else if (r_item.action == scmt_pkg::ACT_REMOVE) begin
                        n_entry = rd_entry;
                        n_j     = r_idx;
                        n_state = S_MRD;
                    end else begin
                        n_entry = rd_entry;
                        n_state = S_OUT;
                    end
                end else if (r_item.action == scmt_pkg::ACT_INSERT) begin
                    if (r_count >= CW'(CAPACITY)) begin
                        n_status = scmt_pkg::ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        n_j     = r_count;
                        n_state = S_MRD;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MRD: begin
                if (r_item.action == scmt_pkg::ACT_INSERT) begin
                    ram_raddr = IW'(r_j - CW'(1));
                    n_state   = (r_j == r_idx) ? S_PUT : S_MWR;
                end else begin
                    ram_raddr = IW'(j_plus);
                    if (j_plus >= {1'b0, r_count}) begin
                        n_count = r_count - CW'(1);
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MWR;
                    end
                end
            end
            S_MWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                ram_wdata = rd_entry;
                n_j       = (r_item.action == scmt_pkg::ACT_INSERT) ?
                            (r_j - CW'(1)) : CW'(j_plus);
                n_state   = S_MRD;
            end
            S_PUT: begin
                ram_we   = 1'b1;
                n_count  = r_count + CW'(1);
                n_status = scmt_pkg::ST_OK;
                n_entry  = new_entry;
                n_state  = S_OUT;
            end
            S_PRD: begin
                ram_raddr = pos_ext[IW-1:0];
                n_state   = (pos_ext < count_pos) ? S_PCAP : S_OUT;
            end
            S_PCAP: begin
                n_status = scmt_pkg::ST_OK;
                n_entry  = rd_entry;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid              = 1'b1;
                    n_odata.status        = r_status;
                    n_odata.found_id      = r_entry.id;
                    n_odata.found_mask    = r_entry.mask;
                    n_odata.found_remote  = r_entry.remote;
                    n_odata.found_length  = r_entry.length;
                    n_odata.found_payload = r_entry.payload;
                    n_odata.found_handler = r_entry.handler;
                    n_odata.entry_total   = count_tot[5:0];
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_item   <= n_item;
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_odata  <= n_odata;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata.status != scmt_pkg::ST_OK) |->
        (r_odata.found_id == '0 && r_odata.found_payload == '0))
        else $error("entry fields not cleared on a failed action");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_MWR || r_state == S_PUT || r_state == S_SCMP))
        else $error("memory written outside an update step");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("sequencer idle straight after taking an item");

endmodule
